// File: hdl/hstm_pkg.sv
// Shared types and constants for the heater safety trip monitor.
package hstm_pkg;

  typedef enum logic [1:0] {
    ACT_CHECK   = 2'd0,
    ACT_COOLANT = 2'd1,
    ACT_FLOW    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_PRESENT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_TIMEOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 3'd4;

  localparam logic signed [11:0] OVERHEAT_LIMIT_RST = 12'sd1520;
  localparam logic signed [11:0] RECOVERY_LIMIT_RST = 12'sd1280;
  localparam logic [31:0]        FLOW_TIMEOUT_RST   = 32'd5000;
  localparam logic [15:0]        CHECK_INTERVAL_RST = 16'd1000;

  // Valid coolant range, -55 C to 125 C in sixteenths.
  localparam logic signed [12:0] COOLANT_MIN = -13'sd880;
  localparam logic signed [12:0] COOLANT_MAX = 13'sd2000;

  // Trip mask bit positions.
  localparam int TRIP_OVERHEAT = 0;
  localparam int TRIP_FLOW     = 1;
  localparam int TRIP_LINK     = 2;
  localparam int TRIP_ERROR    = 3;

  typedef struct packed {
    logic              flow_sensor_present;
    logic signed [11:0] overheat_limit;
    logic signed [11:0] recovery_limit;
    logic [31:0]       flow_loss_ms;
    logic [15:0]       check_interval_ms;
  } cfg_t;

  typedef struct packed {
    action_t           action;
    logic [31:0]       now_ms;
    logic signed [12:0] coolant_sixteenths;
    logic              coolant_not_number;
    logic [15:0]       flow_rate;
    logic [31:0]       pulse_time_ms;
    logic              heater_active;
    logic              link_timed_out;
    logic              status_valid;
    logic              heater_fault;
    logic              link_online;
  } item_t;

  typedef struct packed {
    logic       shutdown_request;
    logic [3:0] trip_mask;
    logic       clear_accepted;
    logic       check_ran;
    logic       coolant_ok;
  } result_t;

endpackage

// File: hdl/hstm_cfg_regs.sv
// Configuration register file of the trip monitor.
module hstm_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hstm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hstm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output hstm_pkg::cfg_t                  cfg
);
  import hstm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flow_sensor_present <= 1'b0;
      cfg.overheat_limit      <= OVERHEAT_LIMIT_RST;
      cfg.recovery_limit      <= RECOVERY_LIMIT_RST;
      cfg.flow_loss_ms        <= FLOW_TIMEOUT_RST;
      cfg.check_interval_ms   <= CHECK_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FLOW_PRESENT:   cfg.flow_sensor_present <= cfg_wdata[0];
        CFG_OVERHEAT_LIMIT: cfg.overheat_limit      <= cfg_wdata[11:0];
        CFG_RECOVERY_LIMIT: cfg.recovery_limit      <= cfg_wdata[11:0];
        CFG_FLOW_TIMEOUT:   cfg.flow_loss_ms        <= cfg_wdata[31:0];
        CFG_CHECK_INTERVAL: cfg.check_interval_ms   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/hstm_core.sv
// Trip evaluation and latched safety state of the trip monitor.
module hstm_core (
  input  logic              clk,
  input  logic              rst,
  input  hstm_pkg::cfg_t    cfg,
  input  hstm_pkg::item_t   item,
  input  logic              fire,
  output hstm_pkg::result_t result
);
  import hstm_pkg::*;

  logic signed [12:0] coolant_value, coolant_value_next;
  logic               coolant_valid, coolant_valid_next;
  logic [31:0]        last_flow_ms, last_flow_ms_next;
  logic [31:0]        last_check_ms, last_check_ms_next;
  logic [3:0]         trips, trips_next;

  logic        temp_bad;
  logic [31:0] since_check;
  logic [31:0] since_flow;
  logic [3:0]  set_mask;
  logic        clear_ok;

  assign temp_bad = item.coolant_not_number ||
                    (item.coolant_sixteenths < COOLANT_MIN) ||
                    (item.coolant_sixteenths > COOLANT_MAX);
  assign since_check = item.now_ms - last_check_ms;
  assign since_flow  = item.now_ms - last_flow_ms;

  always_comb begin
    set_mask = '0;
    set_mask[TRIP_LINK]  = item.link_timed_out;
    set_mask[TRIP_ERROR] = item.status_valid && item.heater_fault;
    if (item.heater_active) begin
      set_mask[TRIP_OVERHEAT] = coolant_valid &&
        (coolant_value > $signed({cfg.overheat_limit[11], cfg.overheat_limit}));
      set_mask[TRIP_FLOW] = cfg.flow_sensor_present && (last_flow_ms != '0) &&
                            (since_flow > cfg.flow_loss_ms);
    end
  end

  always_comb begin
    clear_ok = 1'b1;
    if (trips[TRIP_OVERHEAT] && (!coolant_valid ||
        coolant_value > $signed({cfg.recovery_limit[11], cfg.recovery_limit})))
      clear_ok = 1'b0;
    if (trips[TRIP_ERROR] && item.status_valid && item.heater_fault)
      clear_ok = 1'b0;
    if (trips[TRIP_LINK] && !item.link_online)
      clear_ok = 1'b0;
  end

  always_comb begin
    coolant_value_next     = coolant_value;
    coolant_valid_next     = coolant_valid;
    last_flow_ms_next      = last_flow_ms;
    last_check_ms_next     = last_check_ms;
    trips_next             = trips;
    result.shutdown_request = 1'b0;
    result.clear_accepted   = 1'b0;
    result.check_ran        = 1'b0;
    case (item.action)
      ACT_COOLANT: begin
        if (temp_bad) begin
          coolant_valid_next = 1'b0;
        end else begin
          coolant_value_next = item.coolant_sixteenths;
          coolant_valid_next = 1'b1;
        end
      end
      ACT_FLOW: begin
        if (item.pulse_time_ms != '0) begin
          last_flow_ms_next = item.pulse_time_ms;
        end else if (item.flow_rate != '0) begin
          last_flow_ms_next = item.now_ms;
        end
      end
      ACT_CHECK: begin
        if (since_check >= {16'd0, cfg.check_interval_ms}) begin
          result.check_ran   = 1'b1;
          last_check_ms_next = item.now_ms;
          if (trips != '0) begin
            result.shutdown_request = 1'b1;
          end else begin
            // Nothing latched yet, so any set reason is new.
            result.shutdown_request = (set_mask != '0);
            trips_next              = set_mask;
          end
        end
      end
      ACT_CLEAR: begin
        if (clear_ok) begin
          trips_next            = '0;
          result.clear_accepted = 1'b1;
        end
      end
      default: ;
    endcase
    result.trip_mask  = trips_next;
    result.coolant_ok = coolant_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coolant_value <= '0;
      coolant_valid <= 1'b0;
      last_flow_ms  <= '0;
      last_check_ms <= '0;
      trips         <= '0;
    end else if (fire) begin
      coolant_value <= coolant_value_next;
      coolant_valid <= coolant_valid_next;
      last_flow_ms  <= last_flow_ms_next;
      last_check_ms <= last_check_ms_next;
      trips         <= trips_next;
    end
  end

endmodule

// File: hdl/heater_safety_trip_monitor_top.sv
// Top level of the heater safety trip monitor: stream ports, staging registers, checks.
//
// Latching safety interlock for a coolant heater. Each request on the slave
// stream is one event (check tick, coolant sample, flow sample or clear
// request, selected by s_tuser) and yields exactly one result on the master
// stream. A request is registered on acceptance, evaluated against the
// latched state when it advances into the output register, and its
// result lands there in the same edge that updates the state and raises
// m_tvalid. One request per cycle is sustained while m_tready stays
// high: the input
// register refills while the output register is drained, and s_tready drops
// only when both stages hold an item and m_tready is low. Configuration
// registers (0 flow sensor present, 1 overheat limit, 2 recovery limit,
// 3 flow timeout, 4 check interval) are written through cfg_we/cfg_index/
// cfg_wdata and must only change while no request is in flight. Times are
// in milliseconds modulo 2^32; temperatures are signed 1/16 C.
module heater_safety_trip_monitor_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hstm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hstm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, low bit up: now_ms[31:0], coolant_sixteenths[44:32],
  // coolant_not_number[45], flow_rate[61:46], pulse_time_ms[93:62],
  // heater_active[94], link_timed_out[95], status_valid[96],
  // heater_fault[97], link_online[98], zero fill [103:99]
  input  logic [103:0]                    s_tdata,
  // s_tuser: action[1:0]
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, low bit up: shutdown_request[0], trip_mask[4:1],
  // clear_accepted[5], check_ran[6], coolant_ok[7]
  output logic [7:0]                      m_tdata
);
  import hstm_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  result_t result;
  result_t result_q;
  logic    advance;

  hstm_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  // Move the staged request into the result register when that slot is free.
  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  // Hold the accepted request; payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.action             <= action_t'(s_tuser);
      item.now_ms             <= s_tdata[31:0];
      item.coolant_sixteenths <= s_tdata[44:32];
      item.coolant_not_number <= s_tdata[45];
      item.flow_rate          <= s_tdata[61:46];
      item.pulse_time_ms      <= s_tdata[93:62];
      item.heater_active      <= s_tdata[94];
      item.link_timed_out     <= s_tdata[95];
      item.status_valid       <= s_tdata[96];
      item.heater_fault       <= s_tdata[97];
      item.link_online        <= s_tdata[98];
    end
  end

  hstm_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .item  (item),
    .fire  (advance),
    .result(result)
  );

  // Result register: fill on advance, drop when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_tdata = {result_q.coolant_ok, result_q.check_ran, result_q.clear_accepted,
                    result_q.trip_mask, result_q.shutdown_request};

  // A successful clear always leaves the mask empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result_q.clear_accepted |-> result_q.trip_mask == 4'd0)
    else $error("clear accepted with reasons still latched");

  // Shutdown is only requested with some reason latched.
  a_shutdown_has_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && result_q.shutdown_request |-> result_q.trip_mask != 4'd0)
    else $error("shutdown requested with empty trip mask");

  // A check result and a clear result never coincide.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(result_q.check_ran && result_q.clear_accepted))
    else $error("check and clear flagged together");

  // A staged request stays staged while the output is stalled.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    item_valid && m_tvalid && !m_tready |=> item_valid)
    else $error("staged request lost during stall");

endmodule
